// ----- sv/matmul_reuse_factor_planner_core_macros.svh -----
// Assertion macros for the reuse factor planner pick stage.
`ifndef MATMUL_REUSE_FACTOR_PLANNER_CORE_MACROS_SVH
`define MATMUL_REUSE_FACTOR_PLANNER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MRFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mrfp_pkg.sv -----
// Shared widths, codes, stage payload types and helpers of the reuse factor planner.
package mrfp_pkg;

  localparam int DIM_W   = 16;
  localparam int REQ_W   = 8;
  localparam int CACHE_W = 11;
  localparam int TILE_W  = 16;
  localparam int LIM_W   = 10;
  localparam int HALF_W  = CACHE_W - 1;

  localparam int TILE_SIZE_DEF            = 16;
  localparam int DEFAULT_CACHE_BLOCKS_DEF = 16;
  localparam int FRAME_COUNT_DEF          = 8;

  localparam logic OP_SELECT   = 1'b0;
  localparam logic OP_LEGALIZE = 1'b1;

  typedef struct packed {
    logic              op;
    logic              is;
    logic [DIM_W-1:0]  dim_k;
    logic [DIM_W-1:0]  dim_n;
    logic [DIM_W-1:0]  dim_m;
    logic [REQ_W-1:0]  req_ia;
    logic [REQ_W-1:0]  req_w;
  } mrfp_req_t;

  typedef struct packed {
    logic              op;
    logic              is;
    logic              zero_sel;
    logic [TILE_W-1:0] row_t;
    logic [TILE_W-1:0] col_t;
    logic [HALF_W-1:0] half;
    logic [REQ_W-1:0]  req_ia;
    logic [REQ_W-1:0]  req_w;
  } mrfp_tiles_t;

  typedef struct packed {
    logic              op;
    logic              is;
    logic              zero_sel;
    logic [LIM_W-1:0]  ia_lim;
    logic [LIM_W-1:0]  w_lim;
    logic [TILE_W-1:0] col_t;
    logic [REQ_W-1:0]  req_ia;
    logic [REQ_W-1:0]  req_w;
  } mrfp_lims_t;

  function automatic logic [TILE_W-1:0] mrfp_pow2_floor(input logic [TILE_W-1:0] v);
    logic [TILE_W-1:0] r;
    r = TILE_W'(1);
    for (int i = 1; i < TILE_W; i++) begin
      if (v[i]) begin
        r = TILE_W'(1) << i;
      end
    end
    return r;
  endfunction

  function automatic logic [TILE_W-1:0] mrfp_min(input logic [TILE_W-1:0] a,
                                                  input logic [TILE_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ----- sv/mrfp_tile_stage.sv -----
// First stage: tile counts by reciprocal multiply, cache half limit and zero check.
module mrfp_tile_stage #(
  parameter int TILE_SIZE            = mrfp_pkg::TILE_SIZE_DEF,
  parameter int DEFAULT_CACHE_BLOCKS = mrfp_pkg::DEFAULT_CACHE_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mrfp_pkg::CACHE_W-1:0]  cache_blocks,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mrfp_pkg::mrfp_req_t           in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mrfp_pkg::mrfp_tiles_t         out_item
);
  import mrfp_pkg::*;

  localparam int SUM_W   = DIM_W + 1;
  localparam int TLOG    = $clog2(TILE_SIZE);
  localparam int SHIFT   = SUM_W + TLOG;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SHIFT + TILE_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** SHIFT) + TILE_SIZE - 1) / TILE_SIZE);

  logic [DIM_W-1:0]   row_d;
  logic [DIM_W-1:0]   col_d;
  logic [SUM_W-1:0]   row_sum;
  logic [SUM_W-1:0]   col_sum;
  logic [PROD_W-1:0]  row_prod;
  logic [PROD_W-1:0]  col_prod;
  logic [TILE_W-1:0]  row_q;
  logic [TILE_W-1:0]  col_q;
  logic [CACHE_W-1:0] blocks;
  logic [HALF_W-1:0]  half_raw;
  mrfp_tiles_t        item_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    row_d    = in_item.is ? in_item.dim_m : in_item.dim_k;
    col_d    = in_item.is ? in_item.dim_k : in_item.dim_m;
    row_sum  = SUM_W'(row_d) + SUM_W'(TILE_SIZE - 1);
    col_sum  = SUM_W'(col_d) + SUM_W'(TILE_SIZE - 1);
    row_prod = PROD_W'(row_sum) * PROD_W'(RECIP);
    col_prod = PROD_W'(col_sum) * PROD_W'(RECIP);
    row_q    = row_prod[SHIFT +: TILE_W];
    col_q    = col_prod[SHIFT +: TILE_W];
    blocks   = (cache_blocks == '0) ? CACHE_W'(DEFAULT_CACHE_BLOCKS) : cache_blocks;
    half_raw = blocks[CACHE_W-1:1];

    item_next.op       = in_item.op;
    item_next.is       = in_item.is;
    item_next.zero_sel = (in_item.op == OP_SELECT) &&
                         ((in_item.dim_k == '0) || (in_item.dim_n == '0) ||
                          (in_item.dim_m == '0));
    item_next.row_t    = (row_q == '0) ? TILE_W'(1) : row_q;
    item_next.col_t    = (col_q == '0) ? TILE_W'(1) : col_q;
    item_next.half     = (half_raw == '0) ? HALF_W'(1) : half_raw;
    item_next.req_ia   = in_item.req_ia;
    item_next.req_w    = in_item.req_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// ----- sv/mrfp_limit_stage.sv -----
// Second stage: activation and weight limits rounded down to powers of two.
module mrfp_limit_stage #(
  parameter int FRAME_COUNT = mrfp_pkg::FRAME_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mrfp_pkg::mrfp_tiles_t in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mrfp_pkg::mrfp_lims_t  out_item
);
  import mrfp_pkg::*;

  logic [TILE_W-1:0] ia_p2;
  logic [TILE_W-1:0] w_p2;
  mrfp_lims_t        item_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    ia_p2 = mrfp_pow2_floor(mrfp_min(in_item.row_t, TILE_W'(in_item.half)));
    w_p2  = mrfp_pow2_floor(mrfp_min(in_item.col_t, TILE_W'(FRAME_COUNT)));

    item_next.op       = in_item.op;
    item_next.is       = in_item.is;
    item_next.zero_sel = in_item.zero_sel;
    item_next.ia_lim   = ia_p2[LIM_W-1:0];
    item_next.w_lim    = w_p2[LIM_W-1:0];
    item_next.col_t    = in_item.col_t;
    item_next.req_ia   = in_item.req_ia;
    item_next.req_w    = in_item.req_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// ----- sv/mrfp_pick_stage.sv -----
// Last stage: coupling, select or legalize, weight raise and the output register.
module mrfp_pick_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mrfp_pkg::mrfp_lims_t        in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mrfp_pkg::LIM_W-1:0]  out_ia,
  output logic [mrfp_pkg::LIM_W-1:0]  out_w
);
  import mrfp_pkg::*;
  `include "matmul_reuse_factor_planner_core_macros.svh"

  logic [LIM_W-1:0]  ia_lim;
  logic [TILE_W-1:0] ia_p2;
  logic [TILE_W-1:0] w_p2;
  logic [LIM_W-1:0]  leg_ia;
  logic [LIM_W-1:0]  leg_w;
  logic [LIM_W-1:0]  ia_next;
  logic [LIM_W-1:0]  w_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    ia_lim = (in_item.is && (in_item.w_lim < in_item.ia_lim)) ? in_item.w_lim
                                                              : in_item.ia_lim;
    ia_p2  = mrfp_pow2_floor(mrfp_min(TILE_W'(in_item.req_ia), TILE_W'(ia_lim)));
    w_p2   = mrfp_pow2_floor(mrfp_min(TILE_W'(in_item.req_w), TILE_W'(in_item.w_lim)));
    leg_ia = (in_item.req_ia != '0) ? ia_p2[LIM_W-1:0] : '0;
    leg_w  = (in_item.req_w != '0) ? w_p2[LIM_W-1:0] : '0;
    if (in_item.is && (leg_ia != '0) && (leg_w != '0) && (leg_w < leg_ia) &&
        (in_item.col_t >= TILE_W'(leg_ia))) begin
      leg_w = leg_ia;
    end
    if (in_item.zero_sel) begin
      ia_next = LIM_W'(1);
      w_next  = LIM_W'(1);
    end else if (in_item.op == OP_SELECT) begin
      ia_next = ia_lim;
      w_next  = in_item.w_lim;
    end else begin
      ia_next = leg_ia;
      w_next  = leg_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_ia <= ia_next;
      out_w  <= w_next;
    end
  end

  `MRFP_ASSERT_NEXT(a_zero_dim_gives_one, in_valid && in_ready && in_item.zero_sel,
    (out_ia == LIM_W'(1)) && (out_w == LIM_W'(1)), "zero dimension select not one")
  `MRFP_ASSERT_NEXT(a_select_nonzero, in_valid && in_ready && (in_item.op == OP_SELECT),
    (out_ia != '0) && (out_w != '0), "select produced a zero reuse")
  `MRFP_ASSERT_NEXT(a_is_select_coupled,
    in_valid && in_ready && (in_item.op == OP_SELECT) && in_item.is && !in_item.zero_sel,
    out_ia <= out_w, "input stationary activation reuse above weight reuse")

endmodule

// ----- sv/matmul_reuse_factor_planner_core.sv -----
// Reuse factor planner: three register stages, one request per cycle while the
// output is taken. A request passes the tile, limit and pick stage registers in
// that order. A stage takes a new request whenever its register is empty or the
// stage after it takes the request it holds. Requests therefore stream back to
// back while the output is taken, and a stalled output backs the stages up
// without loss. The first stage holds the reciprocal multiplies that divide K and
// M by the tile size. The cache_blocks register is written over the cfg channel,
// which is always ready; write it only while no request is in flight.
module matmul_reuse_factor_planner_core #(
  parameter int TILE_SIZE            = mrfp_pkg::TILE_SIZE_DEF,
  parameter int DEFAULT_CACHE_BLOCKS = mrfp_pkg::DEFAULT_CACHE_BLOCKS_DEF,
  parameter int FRAME_COUNT          = mrfp_pkg::FRAME_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mrfp_pkg::CACHE_W-1:0] cfg_data,   // cache_blocks
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [63:0]                  s_tdata,    // dim_k, dim_n, dim_m, requested_ia_reuse, requested_w_reuse
  input  logic [1:0]                   s_tuser,    // operation, input_stationary
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata     // ia_reuse, w_reuse, zero pad
);
  import mrfp_pkg::*;

  logic [CACHE_W-1:0] cache_blocks;
  mrfp_req_t          req;
  logic               tile_valid;
  logic               tile_ready;
  mrfp_tiles_t        tile_item;
  logic               lim_valid;
  logic               lim_ready;
  mrfp_lims_t         lim_item;
  logic [LIM_W-1:0]   ia_reuse;
  logic [LIM_W-1:0]   w_reuse;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_blocks <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cache_blocks <= cfg_data;
    end
  end

  always_comb begin
    req.op     = s_tuser[0];
    req.is     = s_tuser[1];
    req.dim_k  = s_tdata[15:0];
    req.dim_n  = s_tdata[31:16];
    req.dim_m  = s_tdata[47:32];
    req.req_ia = s_tdata[55:48];
    req.req_w  = s_tdata[63:56];
  end

  mrfp_tile_stage #(
    .TILE_SIZE            (TILE_SIZE),
    .DEFAULT_CACHE_BLOCKS (DEFAULT_CACHE_BLOCKS)
  ) u_tile (
    .clk          (clk),
    .rst          (rst),
    .cache_blocks (cache_blocks),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_item      (req),
    .out_valid    (tile_valid),
    .out_ready    (tile_ready),
    .out_item     (tile_item)
  );

  mrfp_limit_stage #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_limit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tile_valid),
    .in_ready  (tile_ready),
    .in_item   (tile_item),
    .out_valid (lim_valid),
    .out_ready (lim_ready),
    .out_item  (lim_item)
  );

  mrfp_pick_stage u_pick (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lim_valid),
    .in_ready  (lim_ready),
    .in_item   (lim_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ia    (ia_reuse),
    .out_w     (w_reuse)
  );

  assign m_tdata = {4'b0000, w_reuse, ia_reuse};

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the reuse factor planner: streamed requests, predicted results.
`timescale 1ns / 100ps

module tb_top;

  import mrfp_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int ITEMS_PER_SET = 130;
  localparam int HOLD_CYCLES   = 90;

  typedef struct packed {
    logic [LIM_W-1:0] w_reuse;
    logic [LIM_W-1:0] ia_reuse;
  } reuse_t;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CACHE_W-1:0]  cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [63:0]         s_tdata;   // dim_k, dim_n, dim_m, requested_ia_reuse, requested_w_reuse
  logic [1:0]          s_tuser;   // operation, input_stationary
  logic                m_tvalid;
  logic                m_tready;
  logic [23:0]         m_tdata;   // ia_reuse, w_reuse, zero pad

  mrfp_req_t           req_pending[$];
  reuse_t              reuse_expected[$];
  logic [CACHE_W-1:0]  cache_shadow;
  int unsigned         drv_issued;
  int unsigned         in_accepted;
  int unsigned         results_seen;
  int unsigned         cfg_done;
  int unsigned         err_cnt;
  int unsigned         cycles;
  int unsigned         tx_idle_pct;
  int unsigned         rx_idle_pct;
  int unsigned         hold_left;
  int unsigned         settings_run;

  matmul_reuse_factor_planner_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned floor_pow2(input int unsigned v);
    int unsigned r;
    r = 1;
    while (r * 2 <= v) begin
      r = r * 2;
    end
    return r;
  endfunction

  function automatic int unsigned tile_count(input logic [DIM_W-1:0] d);
    int unsigned t;
    t = (int'(d) + TILE_SIZE_DEF - 1) / TILE_SIZE_DEF;
    return (t < 1) ? 1 : t;
  endfunction

  function automatic reuse_t plan_reuse(input mrfp_req_t r, input logic [CACHE_W-1:0] cache);
    int unsigned blocks;
    int unsigned row_t;
    int unsigned col_t;
    int unsigned ia_lim;
    int unsigned w_lim;
    int unsigned ia;
    int unsigned w;
    reuse_t      res;
    if (r.op == OP_SELECT && (r.dim_k == 0 || r.dim_n == 0 || r.dim_m == 0)) begin
      res.ia_reuse = LIM_W'(1);
      res.w_reuse  = LIM_W'(1);
      return res;
    end
    blocks = (cache == 0) ? DEFAULT_CACHE_BLOCKS_DEF : cache;
    row_t  = tile_count(r.is ? r.dim_m : r.dim_k);
    col_t  = tile_count(r.is ? r.dim_k : r.dim_m);
    ia_lim = (blocks < 2) ? 1 : blocks / 2;
    ia_lim = floor_pow2((row_t < ia_lim) ? row_t : ia_lim);
    w_lim  = floor_pow2((col_t < FRAME_COUNT_DEF) ? col_t : FRAME_COUNT_DEF);
    if (r.is && w_lim < ia_lim) begin
      ia_lim = w_lim;
    end
    if (r.op == OP_SELECT) begin
      ia = ia_lim;
      w  = w_lim;
    end else begin
      ia = (r.req_ia == 0) ? 0 : floor_pow2((r.req_ia < ia_lim) ? r.req_ia : ia_lim);
      w  = (r.req_w == 0) ? 0 : floor_pow2((r.req_w < w_lim) ? r.req_w : w_lim);
      if (r.is && ia != 0 && w != 0 && w < ia && col_t >= ia) begin
        w = ia;
      end
    end
    res.ia_reuse = ia[LIM_W-1:0];
    res.w_reuse  = w[LIM_W-1:0];
    return res;
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) begin
      return '0;
    end else if (sel < 40) begin
      return DIM_W'($urandom_range(300));
    end else if (sel < 55) begin
      return DIM_W'(TILE_SIZE_DEF * $urandom_range(1, 40) + $urandom_range(2) - 1);
    end else if (sel < 63) begin
      return '1;
    end
    return DIM_W'($urandom);
  endfunction

  function automatic logic [REQ_W-1:0] rand_request();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) begin
      return '0;
    end else if (sel < 28) begin
      return '1;
    end else if (sel < 55) begin
      return REQ_W'(1 << $urandom_range(7));
    end
    return REQ_W'($urandom);
  endfunction

  task automatic queue_req(input logic op, input logic is, input int unsigned k,
                           input int unsigned n, input int unsigned m,
                           input int unsigned ria, input int unsigned rw);
    mrfp_req_t r;
    r.op     = op;
    r.is     = is;
    r.dim_k  = DIM_W'(k);
    r.dim_n  = DIM_W'(n);
    r.dim_m  = DIM_W'(m);
    r.req_ia = REQ_W'(ria);
    r.req_w  = REQ_W'(rw);
    req_pending.push_back(r);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (!(req_pending.size() == 0 && in_accepted == drv_issued &&
             reuse_expected.size() == 0));
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cache(input logic [CACHE_W-1:0] v);
    int unsigned n;
    n = cfg_done;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (cfg_done == n);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // drive requests
  always @(negedge clk) begin : drive_req
    mrfp_req_t nxt;
    logic      offer;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && in_accepted != drv_issued)) begin
      offer = req_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct;
      if (offer) begin
        nxt = req_pending.pop_front();
        s_tdata <= {nxt.req_w, nxt.req_ia, nxt.dim_m, nxt.dim_n, nxt.dim_k};
        s_tuser <= {nxt.is, nxt.op};
        drv_issued++;
      end
      s_tvalid <= offer;
    end
  end

  // drive result ready, with an optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // sample handshakes, predict and compare
  always @(posedge clk) begin : monitor
    mrfp_req_t r;
    reuse_t    got;
    reuse_t    exp_r;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cache_shadow <= cfg_data;
        cfg_done++;
      end
      if (s_tvalid && s_tready) begin
        r.op     = s_tuser[0];
        r.is     = s_tuser[1];
        r.dim_k  = s_tdata[15:0];
        r.dim_n  = s_tdata[31:16];
        r.dim_m  = s_tdata[47:32];
        r.req_ia = s_tdata[55:48];
        r.req_w  = s_tdata[63:56];
        reuse_expected.push_back(plan_reuse(r, cache_shadow));
        in_accepted++;
      end
      if (m_tvalid && m_tready) begin
        got.ia_reuse = m_tdata[9:0];
        got.w_reuse  = m_tdata[19:10];
        results_seen++;
        if (reuse_expected.size() == 0) begin
          $display("%0t: unexpected result ia_reuse=%0d w_reuse=%0d",
                   $time, got.ia_reuse, got.w_reuse);
          err_cnt++;
        end else begin
          exp_r = reuse_expected.pop_front();
          if (got.ia_reuse !== exp_r.ia_reuse) begin
            $display("%0t: ia_reuse expected %0d actual %0d",
                     $time, exp_r.ia_reuse, got.ia_reuse);
            err_cnt++;
          end
          if (got.w_reuse !== exp_r.w_reuse) begin
            $display("%0t: w_reuse expected %0d actual %0d",
                     $time, exp_r.w_reuse, got.w_reuse);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, reuse_expected.size());
      $display("[matmul_reuse_factor_planner_core] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CACHE_W-1:0] cache_set[12];
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    m_tready     = 1'b0;
    cache_shadow = '0;
    drv_issued   = 0;
    in_accepted  = 0;
    results_seen = 0;
    cfg_done     = 0;
    err_cnt      = 0;
    cycles       = 0;
    hold_left    = 0;
    settings_run = 0;
    tx_idle_pct  = 35;
    rx_idle_pct  = 69;
    cache_set = '{11'd0, 11'd2047, 11'd1, 11'd2, 11'd3, 11'd1024, 11'd16, 11'd33,
                  11'd256, 11'd1023, CACHE_W'($urandom_range(4, 2047)),
                  CACHE_W'($urandom_range(0, 64))};
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int s = 0; s < 12; s++) begin
      if (s == 4) begin
        tx_idle_pct = 69;
        rx_idle_pct = 35;
      end else if (s == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_cache(cache_set[s]);
      if (s % 4 == 1) begin
        hold_left = HOLD_CYCLES;
      end
      if (s == 0) begin
        // zero dimensions in select
        queue_req(OP_SELECT, 1'b0, 0, 100, 100, 0, 0);
        queue_req(OP_SELECT, 1'b1, 100, 0, 100, 0, 0);
        queue_req(OP_SELECT, 1'b0, 100, 100, 0, 0, 0);
        queue_req(OP_SELECT, 1'b1, 0, 0, 0, 255, 255);
        // select at the extremes and tile boundaries
        queue_req(OP_SELECT, 1'b0, 65535, 65535, 65535, 0, 0);
        queue_req(OP_SELECT, 1'b1, 65535, 65535, 65535, 255, 255);
        queue_req(OP_SELECT, 1'b0, 1, 1, 1, 0, 0);
        queue_req(OP_SELECT, 1'b1, 16, 1, 17, 0, 0);
        queue_req(OP_SELECT, 1'b0, 17, 1, 16, 0, 0);
        queue_req(OP_SELECT, 1'b1, 128, 5, 32, 0, 0);
        // legalize: zero requests, zero dimensions, large requests
        queue_req(OP_LEGALIZE, 1'b0, 65535, 65535, 65535, 0, 0);
        queue_req(OP_LEGALIZE, 1'b1, 65535, 65535, 65535, 0, 255);
        queue_req(OP_LEGALIZE, 1'b0, 0, 0, 0, 255, 255);
        queue_req(OP_LEGALIZE, 1'b1, 0, 0, 0, 255, 0);
        queue_req(OP_LEGALIZE, 1'b0, 65535, 65535, 65535, 255, 255);
        queue_req(OP_LEGALIZE, 1'b0, 200, 7, 200, 3, 5);
        // input-stationary raise of the weight reuse
        queue_req(OP_LEGALIZE, 1'b1, 4096, 9, 4096, 8, 1);
        queue_req(OP_LEGALIZE, 1'b1, 4096, 9, 4096, 255, 2);
        queue_req(OP_LEGALIZE, 1'b1, 64, 9, 1000, 4, 1);
        // weight stationary keeps a smaller weight reuse
        queue_req(OP_LEGALIZE, 1'b0, 4096, 9, 4096, 8, 1);
      end
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        queue_req(($urandom_range(1) == 1) ? OP_LEGALIZE : OP_SELECT,
                  1'($urandom_range(1)), rand_dim(), rand_dim(), rand_dim(),
                  rand_request(), rand_request());
      end
      // pause the sender until the pipeline has drained
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Planned %0d requests, compared %0d results over %0d cache_blocks settings,",
             in_accepted, results_seen, settings_run);
    $display("with sender/receiver stalls, a long result hold-off and full-rate streaming.");
    if (err_cnt == 0 && reuse_expected.size() == 0) begin
      $display("[matmul_reuse_factor_planner_core] OK");
    end else begin
      $display("[matmul_reuse_factor_planner_core] ERROR");
    end
    $finish;
  end

endmodule
